FILE: hdl/assert_macros.svh
// Assertion macros shared by the radix digit converter modules.
// Depends on nothing; each user supplies clk and arst_n in its own scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside of reset.
`define SIRD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define SIRD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/sird_pkg.sv
// Shared types and constants of the signed integer to radix digit converter.
// Depends on nothing; the files that use it refer to it by scoped names.
package sird_pkg;

	localparam int MAX_RADIX_DEF    = 16;
	localparam int NUMBER_WIDTH_DEF = 32;

	localparam int SYM_W       = 8;
	localparam int NUM_SYMBOLS = 16;
	localparam int SYM_IDX_W   = 4;
	localparam int LEN_W       = 5;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_IDX_W   = 3;

	localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYM_0_3   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYM_4_7   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SYM_8_11  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SYM_12_15 = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DIVIDE,
		ST_SIGN,
		ST_FETCH,
		ST_PRESENT
	} sird_state_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: hdl/sird_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module sird_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/sird_div.sv
// Restoring divider by a small radix, one quotient bit per cycle.
// Depends on sird_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sird_div #(
	parameter int NUMBER_WIDTH = sird_pkg::NUMBER_WIDTH_DEF,
	parameter int MAX_RADIX    = sird_pkg::MAX_RADIX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sird_pkg::div_ctrl_t            ctrl,
	input  logic [NUMBER_WIDTH-1:0]        dividend,
	input  logic [$clog2(MAX_RADIX+1)-1:0] divisor,
	output sird_pkg::div_stat_t            stat,
	output logic [NUMBER_WIDTH-1:0]        quotient,
	output logic [$clog2(MAX_RADIX)-1:0]   remainder
);

	localparam int RAD_W   = $clog2(MAX_RADIX + 1);
	localparam int DIGIT_W = $clog2(MAX_RADIX);
	localparam int STEP_W  = $clog2(NUMBER_WIDTH);

	logic [NUMBER_WIDTH-1:0] dvd_q;
	logic [DIGIT_W-1:0]      rem_q;
	logic [RAD_W-1:0]        dsr_q;
	logic [STEP_W-1:0]       step_q;
	logic                    busy_q;
	logic                    done_q;

	logic [DIGIT_W:0]   trial;
	logic [DIGIT_W:0]   dsr_ext;
	logic [DIGIT_W:0]   diff;
	logic               ge;
	logic               last_step;

	assign trial     = {rem_q, dvd_q[NUMBER_WIDTH-1]};
	assign dsr_ext   = (DIGIT_W + 1)'(dsr_q);
	assign ge        = (trial >= dsr_ext);
	assign diff      = trial - dsr_ext;
	assign last_step = (step_q == STEP_W'(NUMBER_WIDTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits shift into the dividend register as it empties.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NUMBER_WIDTH-2:0], ge};
			rem_q <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

	`SIRD_ASSERT(a_no_restart, ctrl.start |-> !busy_q, "divider started while busy")
	`SIRD_ASSERT(a_done_pulse, done_q |=> !done_q, "divider done held for two cycles")

endmodule

FILE: hdl/sird_alph.sv
// Alphabet configuration registers, alphabet validity check and symbol lookup.
// Depends on sird_pkg.
module sird_alph #(
	parameter int MAX_RADIX = sird_pkg::MAX_RADIX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sird_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sird_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [$clog2(MAX_RADIX)-1:0]     digit,
	output logic                             ok,
	output logic [$clog2(MAX_RADIX+1)-1:0]   radix,
	output logic [sird_pkg::SYM_W-1:0]       digit_symbol
);

	localparam int RAD_W = $clog2(MAX_RADIX + 1);

	logic [sird_pkg::LEN_W-1:0]                                len_q;
	logic [sird_pkg::NUM_SYMBOLS-1:0][sird_pkg::SYM_W-1:0]     sym_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			sym_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sird_pkg::REG_LENGTH:    len_q        <= cfg_data[sird_pkg::LEN_W-1:0];
				sird_pkg::REG_SYM_0_3:   sym_q[3:0]   <= cfg_data;
				sird_pkg::REG_SYM_4_7:   sym_q[7:4]   <= cfg_data;
				sird_pkg::REG_SYM_8_11:  sym_q[11:8]  <= cfg_data;
				sird_pkg::REG_SYM_12_15: sym_q[15:12] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Only the first len_q symbols count: none may be a sign and no two may match.
	always_comb begin
		ok = (len_q >= sird_pkg::LEN_W'(2)) && (len_q <= sird_pkg::LEN_W'(MAX_RADIX));
		for (int i = 0; i < sird_pkg::NUM_SYMBOLS; i++) begin
			if (sird_pkg::LEN_W'(i) < len_q) begin
				if (sym_q[i] == sird_pkg::SYM_PLUS || sym_q[i] == sird_pkg::SYM_MINUS) begin
					ok = 1'b0;
				end
				for (int j = i + 1; j < sird_pkg::NUM_SYMBOLS; j++) begin
					if (sird_pkg::LEN_W'(j) < len_q && sym_q[j] == sym_q[i]) begin
						ok = 1'b0;
					end
				end
			end
		end
	end

	assign radix        = len_q[RAD_W-1:0];
	assign digit_symbol = sym_q[sird_pkg::SYM_IDX_W'(digit)];

endmodule

FILE: hdl/signed_integer_to_radix_digits.sv
// Signed integer to radix digits: for a negative number the first symbol offered is the sign; each
// digit costs one pass of the shared one-bit-per-cycle divider. A new number is taken only once the
// last symbol of the previous one is in the output register, and output stalls hold the sequencer;
// a number under an invalid alphabet yields no symbols. Reset (arst_n low, asynchronous) clears the
// sequencer, the valid flag of the output register and the configuration; the digit store is not
// cleared.
`include "assert_macros.svh"

module signed_integer_to_radix_digits #(
	parameter int MAX_RADIX    = sird_pkg::MAX_RADIX_DEF,
	parameter int NUMBER_WIDTH = sird_pkg::NUMBER_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,

	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [sird_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sird_pkg::CFG_DATA_W-1:0] cfg_data,

	// Input channel: one number per transaction.
	input  logic                            number_valid,
	output logic                            number_stall,
	input  logic signed [NUMBER_WIDTH-1:0]  number,

	// Output channel: one symbol per transaction.
	output logic                            symbol_valid,
	input  logic                            symbol_stall,
	output logic [sird_pkg::SYM_W-1:0]      symbol,
	output logic                            last
);

	localparam int RAD_W   = $clog2(MAX_RADIX + 1);
	localparam int DIGIT_W = $clog2(MAX_RADIX);
	localparam int CNT_W   = $clog2(NUMBER_WIDTH + 1);
	localparam int AW      = $clog2(NUMBER_WIDTH);

	// Sequencer state and the digit count of the number in flight.
	sird_pkg::sird_state_t state_q, state_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic                  neg_q, neg_d;

	// The number is held here while it is being converted.
	logic [NUMBER_WIDTH-1:0] num_q;

	// Output register: a finished symbol waits here until the transaction completes.
	logic                       out_valid_q;
	logic [sird_pkg::SYM_W-1:0] out_sym_q, out_sym_d;
	logic                       out_last_q, out_last_d;
	logic                       out_load;
	logic                       out_free;

	sird_pkg::div_ctrl_t     div_ctrl;
	sird_pkg::div_stat_t     div_stat;
	logic [NUMBER_WIDTH-1:0] div_dividend;
	logic [NUMBER_WIDTH-1:0] div_quotient;
	logic [DIGIT_W-1:0]      div_remainder;

	logic                    alph_ok;
	logic [RAD_W-1:0]        radix;
	logic [DIGIT_W-1:0]      rd_digit;
	logic [sird_pkg::SYM_W-1:0] digit_symbol;

	logic ram_we;
	logic ram_re;

	logic [NUMBER_WIDTH-1:0] magnitude;
	logic [CNT_W-1:0]        cnt_inc;
	logic [CNT_W-1:0]        cnt_dec;
	logic                    in_accept;

	assign in_accept    = number_valid && !number_stall;
	assign number_stall = (state_q != sird_pkg::ST_IDLE);
	assign out_free     = !out_valid_q || !symbol_stall;

	// The magnitude is taken as unsigned, so the most negative value converts correctly.
	assign magnitude = num_q[NUMBER_WIDTH-1] ? ({NUMBER_WIDTH{1'b0}} - num_q) : num_q;
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign cnt_dec   = cnt_q - CNT_W'(1);

	sird_alph #(
		.MAX_RADIX (MAX_RADIX)
	) u_alph (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.digit        (rd_digit),
		.ok           (alph_ok),
		.radix        (radix),
		.digit_symbol (digit_symbol)
	);

	sird_div #(
		.NUMBER_WIDTH (NUMBER_WIDTH),
		.MAX_RADIX    (MAX_RADIX)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (div_ctrl),
		.dividend  (div_dividend),
		.divisor   (radix),
		.stat      (div_stat),
		.quotient  (div_quotient),
		.remainder (div_remainder)
	);

	// Digit store, least significant digit at address zero.
	sird_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (NUMBER_WIDTH)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (div_remainder),
		.re    (ram_re),
		.raddr (cnt_dec[AW-1:0]),
		.rdata (rd_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sird_pkg::ST_IDLE;
			cnt_q       <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			neg_q   <= neg_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!symbol_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			num_q <= number;
		end
		if (out_load) begin
			out_sym_q  <= out_sym_d;
			out_last_q <= out_last_d;
		end
	end

	// Sequencer. After a transaction the alphabet is checked; an invalid alphabet ends
	// the run with no symbols. Otherwise the divider peels off one digit per pass until
	// the quotient is zero, then the sign of a negative number and the stored digits are emitted from the
	// most significant end.
	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		neg_d          = neg_q;
		div_ctrl.start = 1'b0;
		div_dividend   = div_quotient;
		ram_we         = 1'b0;
		ram_re         = 1'b0;
		out_load       = 1'b0;
		out_sym_d      = digit_symbol;
		out_last_d     = 1'b0;
		case (state_q)
			sird_pkg::ST_IDLE: begin
				if (in_accept) begin
					state_d = sird_pkg::ST_START;
				end
			end
			sird_pkg::ST_START: begin
				cnt_d = '0;
				if (alph_ok) begin
					neg_d          = num_q[NUMBER_WIDTH-1];
					div_ctrl.start = 1'b1;
					div_dividend   = magnitude;
					state_d        = sird_pkg::ST_DIVIDE;
				end else begin
					state_d = sird_pkg::ST_IDLE;
				end
			end
			sird_pkg::ST_DIVIDE: begin
				if (div_stat.done) begin
					ram_we = 1'b1;
					cnt_d  = cnt_inc;
					if (div_quotient == '0 || cnt_inc == CNT_W'(NUMBER_WIDTH)) begin
						state_d = neg_q ? sird_pkg::ST_SIGN : sird_pkg::ST_FETCH;
					end else begin
						div_ctrl.start = 1'b1;
					end
				end
			end
			sird_pkg::ST_SIGN: begin
				if (out_free) begin
					out_load  = 1'b1;
					out_sym_d = sird_pkg::SYM_MINUS;
					state_d   = sird_pkg::ST_FETCH;
				end
			end
			sird_pkg::ST_FETCH: begin
				ram_re  = 1'b1;
				state_d = sird_pkg::ST_PRESENT;
			end
			sird_pkg::ST_PRESENT: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_last_d = (cnt_q == CNT_W'(1));
					cnt_d      = cnt_dec;
					state_d    = (cnt_q == CNT_W'(1)) ? sird_pkg::ST_IDLE : sird_pkg::ST_FETCH;
				end
			end
			default: begin
				state_d = sird_pkg::ST_IDLE;
			end
		endcase
	end

	assign symbol_valid = out_valid_q;
	assign symbol       = out_sym_q;
	assign last         = out_last_q;

	`SIRD_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(NUMBER_WIDTH), "digit count overflow")
	`SIRD_ASSERT(a_done_in_divide, div_stat.done |-> (state_q == sird_pkg::ST_DIVIDE), "stray divide")
	`SIRD_ASSERT(a_sign_not_last, (symbol_valid && symbol == sird_pkg::SYM_MINUS) |-> !last, "sign marked last")

endmodule

FILE: tb/signed_integer_to_radix_digits_test.sv
// Self-checking testbench for the signed integer to radix digit converter.
// Needs sird_pkg and the signed_integer_to_radix_digits RTL. Nothing else is read.
module signed_integer_to_radix_digits_test;

	// Longest stretch that one number can keep the block busy: divider passes for
	// 32 base-2 digits, the digit symbols and the sign, and some margin.
	localparam int DRAIN_CYCLES =
		2 + sird_pkg::NUMBER_WIDTH_DEF * (sird_pkg::NUMBER_WIDTH_DEF + 3) + 64;
	localparam int RANDOM_ITEMS = 380;
	localparam int LONG_HOLD_CYCLES = 3000;
	localparam int TIMEOUT = 200_000_000;

	// Alphabets used by the directed part. Digit value 0 sits in the low byte of the lowest word.
	localparam logic [127:0] HEX_GLYPHS = {"fedc", "ba98", "7654", "3210"};
	localparam logic [127:0] PLUS_INSIDE = {"fedc", "ba98", "7654", "zy+x"};
	localparam logic [127:0] MINUS_INSIDE = {"fedc", "ba98", "7654", "z-yx"};
	localparam logic [127:0] TWIN_INSIDE = {"fedc", "ba98", "7654", "zxyx"};
	localparam logic [127:0] SIGNS_BEYOND = {"fedc", "ba98", "qpx-", "+zyx"};
	localparam logic [127:0] ZERO_BYTE = {"fedc", "ba98", "7654", 32'h7F80FF00};

	typedef struct packed {
		logic [sird_pkg::SYM_W-1:0] symbol;
		logic                       last;
	} glyph_t;

	// Keeps its own copy of the alphabet registers, spells each accepted number into
	// the symbols it must produce, and matches the output stream against them.
	class radix_text_scoreboard;
		logic [sird_pkg::LEN_W-1:0]           radix_len;
		logic [3:0][sird_pkg::CFG_DATA_W-1:0] glyph_words;
		glyph_t                               awaited_glyphs[$];
		int                                   failures;
		int                                   numbers_seen;
		int                                   symbols_checked;

		function new();
			radix_len = '0;
			glyph_words = '0;
			failures = 0;
			numbers_seen = 0;
			symbols_checked = 0;
		endfunction

		function void set_register(logic [sird_pkg::CFG_IDX_W-1:0] idx,
				logic [sird_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				sird_pkg::REG_LENGTH:    radix_len = data[sird_pkg::LEN_W-1:0];
				sird_pkg::REG_SYM_0_3:   glyph_words[0] = data;
				sird_pkg::REG_SYM_4_7:   glyph_words[1] = data;
				sird_pkg::REG_SYM_8_11:  glyph_words[2] = data;
				sird_pkg::REG_SYM_12_15: glyph_words[3] = data;
				default: ;
			endcase
		endfunction

		function logic [sird_pkg::SYM_W-1:0] glyph_of(logic [sird_pkg::SYM_IDX_W-1:0] value);
			return glyph_words[value[3:2]][8 * value[1:0] +: 8];
		endfunction

		function bit alphabet_ok();
			if (radix_len < 2 || radix_len > sird_pkg::MAX_RADIX_DEF)
				return 1'b0;
			for (int i = 0; i < radix_len; i++) begin
				if (glyph_of(4'(i)) == sird_pkg::SYM_PLUS ||
						glyph_of(4'(i)) == sird_pkg::SYM_MINUS)
					return 1'b0;
				for (int j = i + 1; j < radix_len; j++)
					if (glyph_of(4'(i)) == glyph_of(4'(j)))
						return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_number(logic signed [sird_pkg::NUMBER_WIDTH_DEF-1:0] value);
			logic [sird_pkg::NUMBER_WIDTH_DEF-1:0] magnitude;
			logic [sird_pkg::NUMBER_WIDTH_DEF-1:0] radix;
			logic [sird_pkg::SYM_IDX_W-1:0]        digits[$];
			glyph_t                                entry;
			numbers_seen++;
			if (!alphabet_ok())
				return;
			radix = {{(sird_pkg::NUMBER_WIDTH_DEF - sird_pkg::LEN_W){1'b0}}, radix_len};
			// Unsigned negate, so the most negative value keeps its full magnitude.
			magnitude = value[sird_pkg::NUMBER_WIDTH_DEF-1] ? (~value + 1'b1) : value;
			do begin
				digits.push_back(4'(magnitude % radix));
				magnitude = magnitude / radix;
			end while (magnitude != 0);
			if (value[sird_pkg::NUMBER_WIDTH_DEF-1]) begin
				entry.symbol = sird_pkg::SYM_MINUS;
				entry.last = 1'b0;
				awaited_glyphs.push_back(entry);
			end
			for (int k = digits.size() - 1; k >= 0; k--) begin
				entry.symbol = glyph_of(digits[k]);
				entry.last = (k == 0);
				awaited_glyphs.push_back(entry);
			end
		endfunction

		function void check_symbol(logic [sird_pkg::SYM_W-1:0] sym, logic lst);
			glyph_t want;
			if (awaited_glyphs.size() == 0) begin
				$error("unexpected symbol %h (last %b) with nothing awaited", sym, lst);
				failures++;
				return;
			end
			want = awaited_glyphs.pop_front();
			symbols_checked++;
			if (sym !== want.symbol) begin
				$error("symbol: expected %h, got %h", want.symbol, sym);
				failures++;
			end
			if (lst !== want.last) begin
				$error("last: expected %b, got %b", want.last, lst);
				failures++;
			end
		endfunction

		function int outstanding();
			return awaited_glyphs.size();
		endfunction
	endclass

	// Every input of the block is known from time zero.
	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   cfg_we = 1'b0;
	logic [sird_pkg::CFG_IDX_W-1:0]         cfg_index = '0;
	logic [sird_pkg::CFG_DATA_W-1:0]        cfg_data = '0;
	logic                                   number_valid = 1'b0;
	logic                                   number_stall;
	logic signed [sird_pkg::NUMBER_WIDTH_DEF-1:0] number = '0;
	logic                                   symbol_valid;
	logic                                   symbol_stall = 1'b0;
	logic [sird_pkg::SYM_W-1:0]             symbol;
	logic                                   last;

	radix_text_scoreboard tracker = new();

	// When quiet is set, neither side inserts random gaps or stalls.
	bit quiet = 1'b0;
	// Set by the stimulus to make the output side hold off for a long stretch.
	bit hold_output_req = 1'b0;
	int alphabets_loaded = 0;

	signed_integer_to_radix_digits dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.number_valid (number_valid),
		.number_stall (number_stall),
		.number       (number),
		.symbol_valid (symbol_valid),
		.symbol_stall (symbol_stall),
		.symbol       (symbol),
		.last         (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Gap lengths are mostly zero or short, with an occasional long one.
	function automatic int pick_gap();
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Numbers mix full-width random values, small signed values, the extremes of the
	// range and values of random width, so that both short and long digit runs occur.
	function automatic logic signed [sird_pkg::NUMBER_WIDTH_DEF-1:0] pick_number();
		logic [sird_pkg::NUMBER_WIDTH_DEF-1:0] raw;
		raw = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return raw;
			4, 5: return 32'($urandom_range(0, 2000)) - 32'd1000;
			6: begin
				case ($urandom_range(0, 6))
					0: return 32'h0000_0000;
					1: return 32'h0000_0001;
					2: return 32'hFFFF_FFFF;
					3: return 32'h7FFF_FFFF;
					4: return 32'h8000_0000;
					5: return 32'h8000_0001;
					default: return 32'h7FFF_FFFE;
				endcase
			end
			default: begin
				raw = raw >> $urandom_range(0, 31);
				return raw[0] ? -raw : raw;
			end
		endcase
	endfunction

	// Builds a random alphabet. Most are well formed with distinct symbols; the rest
	// carry a sign or a repeated symbol inside the used length, are raw random
	// bytes, or are too short. Slots past the length are left as random bytes.
	task automatic pick_alphabet(output logic [sird_pkg::LEN_W-1:0] len,
			output logic [127:0] glyph_bits);
		logic [15:0][sird_pkg::SYM_W-1:0] glyphs;
		bit                               used[256];
		int                               kind;
		int                               slot;
		int                               other;
		logic [sird_pkg::SYM_W-1:0]       draw;
		kind = $urandom_range(0, 99);
		if (kind < 5)
			len = 5'($urandom_range(0, 1));
		else if ($urandom_range(0, 4) == 0)
			len = $urandom_range(0, 1) ? 5'd2 : 5'd16;
		else
			len = 5'($urandom_range(2, 16));
		for (slot = 0; slot < 16; slot++) begin
			draw = 8'($urandom);
			if (slot < len)
				while (draw == sird_pkg::SYM_PLUS || draw == sird_pkg::SYM_MINUS || used[draw])
					draw = 8'($urandom);
			used[draw] = 1'b1;
			glyphs[slot] = draw;
		end
		if (len >= 2) begin
			slot = $urandom_range(0, len - 1);
			if (kind >= 75 && kind < 85) begin
				glyphs[slot] = $urandom_range(0, 1) ? sird_pkg::SYM_PLUS : sird_pkg::SYM_MINUS;
			end else if (kind >= 85 && kind < 95) begin
				other = (slot + $urandom_range(1, len - 1)) % len;
				glyphs[other] = glyphs[slot];
			end else if (kind >= 95) begin
				for (slot = 0; slot < 16; slot++)
					glyphs[slot] = 8'($urandom);
			end
		end
		glyph_bits = glyphs;
	endtask

	task automatic wait_drained();
		while (tracker.outstanding() != 0)
			@(posedge clk);
	endtask

	// One register write per clock edge. The write enable stays high across a run of
	// writes and is lowered by the caller afterwards.
	task automatic write_register(input logic [sird_pkg::CFG_IDX_W-1:0] idx,
			input logic [sird_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		tracker.set_register(idx, data);
	endtask

	// Reconfigures only once the block is idle: no number is offered, all awaited
	// symbols have come, and long enough has passed for a number that yields nothing
	// to finish as well.
	task automatic load_alphabet(input logic [sird_pkg::LEN_W-1:0] len,
			input logic [127:0] glyph_bits);
		number_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_register(sird_pkg::REG_LENGTH,
			{{(sird_pkg::CFG_DATA_W - sird_pkg::LEN_W){1'b0}}, len});
		write_register(sird_pkg::REG_SYM_0_3, glyph_bits[31:0]);
		write_register(sird_pkg::REG_SYM_4_7, glyph_bits[63:32]);
		write_register(sird_pkg::REG_SYM_8_11, glyph_bits[95:64]);
		write_register(sird_pkg::REG_SYM_12_15, glyph_bits[127:96]);
		cfg_we <= 1'b0;
		alphabets_loaded++;
	endtask

	// Offers one number and waits until the block takes it. Valid stays high only when
	// another number follows at once; a gap drops it here, and any other caller that
	// goes on to something else lowers it before moving on.
	task automatic send_number(input logic signed [sird_pkg::NUMBER_WIDTH_DEF-1:0] value);
		int gap;
		number_valid <= 1'b1;
		number <= value;
		@(posedge clk);
		while (number_stall)
			@(posedge clk);
		tracker.note_number(value);
		gap = pick_gap();
		if (gap > 0) begin
			number_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Output side: checks each symbol transaction and chooses the stall for the next
	// cycle. It alternates free runs with stalls of random length, and serves a long
	// hold when the stimulus asks for one, counting those cycles here.
	initial begin : output_side
		int hold_left;
		int free_left;
		hold_left = 0;
		free_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && symbol_valid === 1'b1 && !symbol_stall)
				tracker.check_symbol(symbol, last);
			if (hold_output_req) begin
				hold_output_req = 1'b0;
				hold_left = LONG_HOLD_CYCLES;
				free_left = 0;
			end else if (hold_left == 0 && free_left == 0) begin
				free_left = quiet ? 16 : $urandom_range(1, 8);
				hold_left = pick_gap();
			end
			if (hold_left > 0) begin
				symbol_stall <= 1'b1;
				hold_left--;
			end else begin
				symbol_stall <= 1'b0;
				if (free_left > 0)
					free_left--;
			end
		end
	end

	initial begin : stimulus
		logic [sird_pkg::LEN_W-1:0] len;
		logic [127:0]               glyph_bits;
		int                         batch;
		int                         spelled;
		bit                         held;
		bit                         paused;
		spelled = 0;
		held = 1'b0;
		paused = 1'b0;

		// Reset is applied once and released at a rising edge.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight out of reset the length is zero, so the alphabet is invalid and
		// no symbols may appear.
		send_number(0);
		send_number(-1);

		// Decimal: zero, single digits, a carry into a second digit, and both ends
		// of the range, the most negative value included.
		load_alphabet(5'd10, HEX_GLYPHS);
		send_number(0);
		send_number(7);
		send_number(-7);
		send_number(10);
		send_number(32'h7FFF_FFFF);
		send_number(32'h8000_0000);
		send_number(-1000000);

		// The widest radix.
		load_alphabet(5'd16, HEX_GLYPHS);
		send_number(32'h7FFF_FFFF);
		send_number(32'h8000_0000);
		send_number(255);
		send_number(-256);

		// Base two: the most negative value gives the longest run, a sign and 32 digits.
		load_alphabet(5'd2, HEX_GLYPHS);
		send_number(32'h8000_0000);
		send_number(32'h7FFF_FFFF);
		send_number(-1);
		send_number(0);

		// Invalid alphabets: too short, a plus or a minus among the used symbols, and a
		// repeated symbol among them.
		load_alphabet(5'd1, HEX_GLYPHS);
		send_number(5);
		load_alphabet(5'd3, PLUS_INSIDE);
		send_number(9);
		load_alphabet(5'd3, MINUS_INSIDE);
		send_number(9);
		load_alphabet(5'd3, TWIN_INSIDE);
		send_number(9);

		// Signs and a repeat that lie past the used length do not matter.
		load_alphabet(5'd3, SIGNS_BEYOND);
		send_number(-42);

		// A zero byte is an ordinary symbol.
		load_alphabet(5'd4, ZERO_BYTE);
		send_number(0);
		send_number(-5);

		// Random part: batches of numbers under random alphabets until about
		// RANDOM_ITEMS numbers have been sent in all. Numbers under an invalid alphabet
		// are dropped by the block.
		while (tracker.numbers_seen < RANDOM_ITEMS) begin
			quiet = 1'b0;
			pick_alphabet(len, glyph_bits);
			load_alphabet(len, glyph_bits);
			quiet = ($urandom_range(0, 5) == 0);
			batch = $urandom_range(20, 45);
			for (int i = 0; i < batch && tracker.numbers_seen < RANDOM_ITEMS; i++) begin
				send_number(pick_number());
				if (tracker.alphabet_ok()) begin
					spelled++;
					// Hold the output back while numbers keep coming, so the block
					// fills up and has to stall its input.
					if (!held && spelled > 60 && i + 8 < batch) begin
						held = 1'b1;
						hold_output_req = 1'b1;
					end
					// Once, stop offering until every awaited symbol has come out.
					if (!paused && spelled > 150 && i + 8 < batch) begin
						paused = 1'b1;
						number_valid <= 1'b0;
						@(posedge clk);
						wait_drained();
					end
				end
			end
			number_valid <= 1'b0;
			@(posedge clk);
		end

		// Wrap up: everything awaited must arrive, and nothing may follow it.
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.outstanding() != 0) begin
			$error("%0d awaited symbols never arrived", tracker.outstanding());
			tracker.failures++;
		end

		$display("Run covered %0d numbers under %0d loaded alphabets; %0d symbols compared.",
			tracker.numbers_seen, alphabets_loaded, tracker.symbols_checked);
		$display("Included invalid alphabets, extreme values, a long output hold and a full pause.");
		if (tracker.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Guard against a hang anywhere in the run.
	initial begin : watchdog
		#(TIMEOUT);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: signed_integer_to_radix_digits.f
+incdir+hdl
hdl/sird_pkg.sv
hdl/sird_ram.sv
hdl/sird_div.sv
hdl/sird_alph.sv
hdl/signed_integer_to_radix_digits.sv
tb/signed_integer_to_radix_digits_test.sv
